// ===== design/b64d_pkg.sv =====
// Shared types, constants and the character map for the Base64 stream decoder.
// No dependencies; the front, queue, back and top level refer to it by scoped names.
`default_nettype none

package b64d_pkg;

  // Group queue depth and its pointer width
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;
  localparam logic [7:0] CHAR_PAD     = 8'd61;
  localparam logic [7:0] LOWER_OFFSET = 8'd71;

  // Byte counts of a group record
  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  // Byte positions within a group word
  localparam logic [1:0] BYTE_HIGH = 2'd0;
  localparam logic [1:0] BYTE_MID  = 2'd1;
  localparam logic [1:0] BYTE_LOW  = 2'd2;

  // Mapped character
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // One decoded group, passed from front to back
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        eom;
    logic        err;
  } group_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Standard alphabet lookup; anything else maps to zero and is flagged
  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t s;
    logic [7:0] t;
    s = '0;
    t = '0;
    case (c) inside
      [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
        t = c - CHAR_UPPER_A;
        s.ok = 1'b1;
      end
      [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
        t = c - LOWER_OFFSET;
        s.ok = 1'b1;
      end
      [CHAR_DIGIT_0:CHAR_DIGIT_9]: begin
        t = c + 8'd4;
        s.ok = 1'b1;
      end
      CHAR_PLUS: begin
        t = 8'd62;
        s.ok = 1'b1;
      end
      CHAR_SLASH: begin
        t = 8'd63;
        s.ok = 1'b1;
      end
      default: begin
        t = '0;
        s.ok = 1'b0;
      end
    endcase
    s.val = t[5:0];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64d_front.sv =====
// Front end: takes characters, maps them and builds one group record per group.
// Depends on b64d_pkg for the character map and the group record type.
`default_nettype none

module b64d_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       char_code,
  input  wire logic             end_of_message,
  input  wire b64d_pkg::q_stat_t q_stat,
  output logic                  push,
  output b64d_pkg::group_t      push_rec
);

  logic [17:0]       acc;
  logic [1:0]        chars_in_group;
  logic [1:0]        pad_seen;
  logic              group_error;

  logic              take;
  logic              is_pad;
  b64d_pkg::sextet_t m;
  logic [1:0]        pads_next;
  logic              err_next;
  logic              group_done;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  // Classify the character against the group state
  always_comb begin
    m         = b64d_pkg::map_char(char_code);
    is_pad    = (char_code == b64d_pkg::CHAR_PAD) && chars_in_group[1];
    pads_next = is_pad ? (pad_seen + 2'd1) : pad_seen;
    err_next  = group_error | (!is_pad && (!m.ok || (pad_seen != 2'd0)));
  end

  assign group_done = (chars_in_group == 2'd3);

  // Group record: full group, or the flagged result of a cut-short group
  always_comb begin
    push = take && (group_done || end_of_message);
    if (!group_done) begin
      push_rec.word   = '0;
      push_rec.nbytes = b64d_pkg::NBYTES_ONE;
      push_rec.eom    = 1'b1;
      push_rec.err    = 1'b1;
    end else begin
      push_rec.word   = {acc, m.val};
      push_rec.nbytes = pads_next[1] ? b64d_pkg::NBYTES_ONE
                                     : (b64d_pkg::NBYTES_THREE - pads_next);
      push_rec.eom    = end_of_message;
      push_rec.err    = err_next;
    end
  end

  // Group state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc            <= '0;
      chars_in_group <= '0;
      pad_seen       <= '0;
      group_error    <= 1'b0;
    end else if (take) begin
      if (group_done || end_of_message) begin
        acc            <= '0;
        chars_in_group <= '0;
        pad_seen       <= '0;
        group_error    <= 1'b0;
      end else begin
        acc            <= {acc[11:0], m.val};
        chars_in_group <= chars_in_group + 2'd1;
        pad_seen       <= pads_next;
        group_error    <= err_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64d_queue.sv =====
// Short register queue of group records between front and back.
// Depends on b64d_pkg for the record type, depth and status struct.
`default_nettype none

module b64d_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b64d_pkg::group_t  push_rec,
  input  wire logic              pop,
  output b64d_pkg::group_t       head,
  output b64d_pkg::q_stat_t      q_stat
);

  b64d_pkg::group_t                  mem [b64d_pkg::QDepth];
  logic [b64d_pkg::QPtrW-1:0]        wr_ptr;
  logic [b64d_pkg::QPtrW-1:0]        rd_ptr;
  logic [b64d_pkg::QCntW-1:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == b64d_pkg::QCntW'(b64d_pkg::QDepth));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64d_back.sv =====
// Back end: splits head group records into output register bytes, one per unstalled cycle.
// Depends on b64d_pkg for the record type and byte position codes.
`default_nettype none

module b64d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64d_pkg::group_t  head,
  input  wire b64d_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             data_byte,
  output logic                   last_of_group,
  output logic                   message_end,
  output logic                   bad_input
);

  logic [1:0] byte_idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !q_stat.empty && (!out_valid || out_ready);
  assign is_last = ((byte_idx + 2'd1) == head.nbytes);
  assign pop     = load && is_last;

  // Byte select, high byte first
  always_comb begin
    case (byte_idx)
      b64d_pkg::BYTE_HIGH: sel_byte = head.word[23:16];
      b64d_pkg::BYTE_MID:  sel_byte = head.word[15:8];
      b64d_pkg::BYTE_LOW:  sel_byte = head.word[7:0];
      default:             sel_byte = '0;
    endcase
  end

  // Output register and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      byte_idx  <= is_last ? 2'd0 : (byte_idx + 2'd1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data_byte     <= sel_byte;
      last_of_group <= is_last;
      message_end   <= is_last && head.eom;
      bad_input     <= head.err;
    end
  end

endmodule

`default_nettype wire

// ===== design/base64_stream_decoder.sv =====
// Top level of the Base64 stream decoder: front end, group queue and byte back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | char_code[7:0], end_of_message
//  out     | out_valid / out_ready| data_byte[7:0], last_of_group, message_end, bad_input
//
// One character is taken per cycle while the group queue has room (4 records).
// Unstalled, the back end sends one byte per cycle: 3 bytes per 4 characters keep pace;
// a completing character's record is queued; its first byte then goes out registered.
// Reset is synchronous and clears group state, queue pointers and the output valid.
// A stall on the output fills the queue; in_ready falls only when it is full.
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            last_of_group,
  output logic            message_end,
  output logic            bad_input
);

  b64d_pkg::group_t  push_rec;
  b64d_pkg::group_t  head;
  b64d_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  b64d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .end_of_message (end_of_message),
    .q_stat         (q_stat),
    .push           (push),
    .push_rec       (push_rec)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  b64d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .last_of_group (last_of_group),
    .message_end   (message_end),
    .bad_input     (bad_input)
  );

  // A message end only ever marks the last byte of a group
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!message_end || last_of_group))
    else $error("message_end without last_of_group");

  // A transfer carrying end of message always leaves a record queued or a byte pending
  a_eom_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_message) |=> (!q_stat.empty || out_valid))
    else $error("end of message transfer produced nothing");

  // No output straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
